// ----- hw/rtl/scm_pkg.sv -----
// Shared types and constants for the scanset character-class matcher.
`timescale 1ns / 1ps

package scm_pkg;

  localparam int unsigned SetBits = 256;

  localparam logic [7:0] ChCaret = 8'h5E;  // '^'
  localparam logic [7:0] ChClose = 8'h5D;  // ']'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'

  localparam logic [2:0] RegMaxWidth = 3'h0;
  localparam logic [2:0] RegSuppress = 3'h4;

  typedef enum logic [1:0] {
    CMD_BEGIN       = 2'd0,
    CMD_SET_CHAR    = 2'd1,
    CMD_STREAM_CHAR = 2'd2,
    CMD_END         = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    PH_FIRST       = 2'd0,
    PH_AFTER_CARET = 2'd1,
    PH_BODY        = 2'd2,
    PH_CLOSED      = 2'd3
  } phase_e;

  typedef struct packed {
    logic       accepted;
    logic [7:0] data_char;
    logic       pushed_back;
    logic       field_done;
    logic       assigned;
    logic       set_closed;
  } res_t;

endpackage

// ----- hw/rtl/scanset_char_class_matcher_top.sv -----
// Scanset character-class matcher: set builder, stream classifier, output skid buffer.
// Results are registered: output register, or skid entry while that is held full.
// Throughput: one input beat per cycle while in_stall_o is low; the membership map
//   (256 flops) is cleared or range-filled in the cycle of the beat that causes it.
// A two-entry output buffer keeps input flowing for one beat while the output stalls.
// Reset (rst_ni low, async): empty, non-negated set, field not ended, registers zero.
`timescale 1ns / 1ps

module scanset_char_class_matcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  ch_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic [7:0]  data_char_o,
  output logic        pushed_back_o,
  output logic        field_done_o,
  output logic        assigned_o,
  output logic        set_closed_o
);
  import scm_pkg::*;

  // configuration registers
  logic [15:0] max_width_q;
  logic        suppress_q;

  // matcher state
  logic [SetBits-1:0] member_q, member_d;
  logic               negated_q, negated_d;
  phase_e             phase_q, phase_d;
  logic [7:0]         held_char_q, held_char_d;
  logic               held_valid_q, held_valid_d;
  logic               dash_q, dash_d;
  logic [15:0]        remaining_q, remaining_d;
  logic               any_q, any_d;
  logic               ended_q, ended_d;

  // output buffer
  res_t res_main_q, res_skid_q, res_new;
  logic main_valid_q, skid_valid_q;

  logic               in_beat, out_beat, cfg_write;
  cmd_e               cmd;
  logic [SetBits-1:0] held_hot, dash_hot, close_hot, range_mask, close_mask, map_closed;
  logic               match;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == RegSuppress) ? {31'b0, suppress_q} : {16'b0, max_width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_width_q <= '0;
      suppress_q  <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == RegMaxWidth[2]) begin
        max_width_q <= pwdata[15:0];
      end else begin
        suppress_q <= pwdata[0];
      end
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_beat    = in_valid_i && !in_stall_o;
  assign out_beat   = main_valid_q && !out_stall_i;
  assign cmd        = cmd_e'(command_i);

  assign held_hot   = {{(SetBits-1){1'b0}}, 1'b1} << held_char_q;
  assign dash_hot   = {{(SetBits-1){1'b0}}, 1'b1} << ChDash;
  assign close_hot  = {{(SetBits-1){1'b0}}, 1'b1} << ChClose;
  // codes from held_char up to ch inclusive; empty when reversed
  assign range_mask = ({SetBits{1'b1}} << held_char_q) & ({SetBits{1'b1}} >> (~ch_i));

  // implicit close on the first stream or end item of an open set
  assign close_mask = (phase_q == PH_CLOSED) ? '0 :
                      ((held_valid_q ? held_hot : '0) | (dash_q ? dash_hot : '0));
  assign map_closed = member_q | close_mask;
  assign match      = map_closed[ch_i] != negated_q;

  always_comb begin
    member_d     = member_q;
    negated_d    = negated_q;
    phase_d      = phase_q;
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    dash_d       = dash_q;
    remaining_d  = remaining_q;
    any_d        = any_q;
    ended_d      = ended_q;
    res_new      = '0;

    unique case (cmd)
      CMD_BEGIN: begin
        member_d     = '0;
        negated_d    = 1'b0;
        phase_d      = PH_FIRST;
        held_char_d  = '0;
        held_valid_d = 1'b0;
        dash_d       = 1'b0;
        remaining_d  = max_width_q;
        any_d        = 1'b0;
        ended_d      = 1'b0;
      end
      CMD_SET_CHAR: begin
        if (!ended_q && phase_q != PH_CLOSED) begin
          if (phase_q == PH_FIRST && ch_i == ChCaret) begin
            negated_d = 1'b1;
            phase_d   = PH_AFTER_CARET;
          end else if ((phase_q == PH_FIRST || phase_q == PH_AFTER_CARET) && ch_i == ChClose) begin
            // leading ']' is a member
            phase_d  = PH_BODY;
            member_d = member_q | close_hot;
          end else begin
            // body character; first positions share this path
            phase_d = PH_BODY;
            if (!held_valid_q) begin
              if (ch_i == ChClose) begin
                phase_d             = PH_CLOSED;
                res_new.set_closed  = 1'b1;
              end else begin
                held_char_d  = ch_i;
                held_valid_d = 1'b1;
              end
            end else if (!dash_q) begin
              if (ch_i == ChDash) begin
                dash_d = 1'b1;
              end else begin
                member_d = member_q | held_hot;
                if (ch_i == ChClose) begin
                  held_valid_d       = 1'b0;
                  phase_d            = PH_CLOSED;
                  res_new.set_closed = 1'b1;
                end else begin
                  held_char_d = ch_i;
                end
              end
            end else if (ch_i == ChClose) begin
              // trailing '-' is literal
              member_d           = member_q | held_hot | dash_hot;
              held_valid_d       = 1'b0;
              dash_d             = 1'b0;
              phase_d            = PH_CLOSED;
              res_new.set_closed = 1'b1;
            end else begin
              member_d    = member_q | range_mask;
              dash_d      = 1'b0;
              held_char_d = ch_i;
            end
          end
        end
      end
      CMD_STREAM_CHAR: begin
        if (!ended_q) begin
          member_d     = map_closed;
          held_valid_d = 1'b0;
          dash_d       = 1'b0;
          phase_d      = PH_CLOSED;
          if (!match) begin
            res_new.pushed_back = 1'b1;
            res_new.field_done  = 1'b1;
            res_new.assigned    = any_q;
            ended_d             = 1'b1;
          end else begin
            res_new.accepted = 1'b1;
            if (!suppress_q) begin
              res_new.data_char = ch_i;
              any_d             = 1'b1;
            end
            if (remaining_q != '0) begin
              remaining_d = remaining_q - 16'd1;
              if (remaining_q == 16'd1) begin
                res_new.field_done = 1'b1;
                res_new.assigned   = any_d;
                ended_d            = 1'b1;
              end
            end
          end
        end
      end
      CMD_END: begin
        if (!ended_q) begin
          member_d           = map_closed;
          held_valid_d       = 1'b0;
          dash_d             = 1'b0;
          phase_d            = PH_CLOSED;
          res_new.field_done = 1'b1;
          res_new.assigned   = any_q;
          ended_d            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_q     <= '0;
      negated_q    <= 1'b0;
      phase_q      <= PH_FIRST;
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
      dash_q       <= 1'b0;
      remaining_q  <= '0;
      any_q        <= 1'b0;
      ended_q      <= 1'b0;
    end else if (in_beat) begin
      member_q     <= member_d;
      negated_q    <= negated_d;
      phase_q      <= phase_d;
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      dash_q       <= dash_d;
      remaining_q  <= remaining_d;
      any_q        <= any_d;
      ended_q      <= ended_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_beat) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        main_valid_q <= in_beat;
      end
    end else if (in_beat) begin
      if (main_valid_q) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_beat) begin
      if (skid_valid_q) begin
        res_main_q <= res_skid_q;
      end else if (in_beat) begin
        res_main_q <= res_new;
      end
    end else if (in_beat) begin
      if (main_valid_q) begin
        res_skid_q <= res_new;
      end else begin
        res_main_q <= res_new;
      end
    end
  end

  assign out_valid_o   = main_valid_q;
  assign accepted_o    = res_main_q.accepted;
  assign data_char_o   = res_main_q.data_char;
  assign pushed_back_o = res_main_q.pushed_back;
  assign field_done_o  = res_main_q.field_done;
  assign assigned_o    = res_main_q.assigned;
  assign set_closed_o  = res_main_q.set_closed;

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held while output register empty");

  a_ended_implies_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ended_q |-> (phase_q == PH_CLOSED))
    else $error("field ended on an open set");

  a_begin_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && cmd == CMD_BEGIN) |=> (!ended_q && phase_q == PH_FIRST && member_q == '0))
    else $error("begin did not reopen the set");

  a_accept_xor_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(accepted_o && pushed_back_o))
    else $error("beat both accepted and pushed back");

  a_data_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && data_char_o != 8'd0) |-> accepted_o)
    else $error("data delivered without accept");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the scanset character-class matcher.
`timescale 1ns / 1ps

module tb_top;
  import scm_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandBeats  = 625;
  localparam int unsigned DirSplit   = 15;
  localparam int unsigned DirRows    = 25;

  localparam res_t R_NONE   = '0;
  localparam res_t R_CLOSED = res_t'{1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1};
  localparam res_t R_REJ0   = res_t'{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0};
  localparam res_t R_REJ1   = res_t'{1'b0, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0};
  localparam res_t R_DONE0  = res_t'{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};

  typedef struct {
    cmd_e       cmd;
    logic [7:0] ch;
    bit         typed;
    res_t       res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CMD_BEGIN;
  logic [7:0]  ch_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        accepted_o;
  logic [7:0]  data_char_o;
  logic        pushed_back_o;
  logic        field_done_o;
  logic        assigned_o;
  logic        set_closed_o;

  scanset_char_class_matcher_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .ch_i         (ch_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o),
    .data_char_o  (data_char_o),
    .pushed_back_o(pushed_back_o),
    .field_done_o (field_done_o),
    .assigned_o   (assigned_o),
    .set_closed_o (set_closed_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  logic [SetBits-1:0] map_bits = '0;
  logic        is_negated = 1'b0;
  phase_e      set_phase = PH_FIRST;
  logic [7:0]  held_ch = '0;
  logic        held_ok = 1'b0;
  logic        dash_pend = 1'b0;
  logic [15:0] width_left = '0;
  logic        got_data = 1'b0;
  logic        fld_over = 1'b0;
  logic [15:0] cfg_width = '0;
  logic        cfg_suppress = 1'b0;

  res_t        pending_results[$];
  res_t        want;
  int          err_cnt = 0;
  int          beats_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          no_gaps = 1'b0;
  dir_row_t    dir_tbl [DirRows];

  // An open set is closed by the first stream or end beat.
  function automatic void close_open_set();
    if (set_phase != PH_CLOSED) begin
      if (held_ok) map_bits[held_ch] = 1'b1;
      if (dash_pend) map_bits[ChDash] = 1'b1;
      held_ok = 1'b0;
      dash_pend = 1'b0;
      set_phase = PH_CLOSED;
    end
  endfunction

  function automatic res_t classify_beat(cmd_e cmd, logic [7:0] c);
    res_t r;
    int   k;
    r = '0;
    case (cmd)
      CMD_BEGIN: begin
        map_bits = '0;
        is_negated = 1'b0;
        set_phase = PH_FIRST;
        held_ch = '0;
        held_ok = 1'b0;
        dash_pend = 1'b0;
        width_left = cfg_width;
        got_data = 1'b0;
        fld_over = 1'b0;
      end
      CMD_SET_CHAR: begin
        if (!fld_over && set_phase != PH_CLOSED) begin
          if (set_phase == PH_FIRST && c == ChCaret) begin
            is_negated = 1'b1;
            set_phase = PH_AFTER_CARET;
          end else if (set_phase != PH_BODY && c == ChClose) begin
            // leading bracket is a member
            map_bits[ChClose] = 1'b1;
            set_phase = PH_BODY;
          end else begin
            set_phase = PH_BODY;
            if (!held_ok) begin
              if (c == ChClose) begin
                set_phase = PH_CLOSED;
                r.set_closed = 1'b1;
              end else begin
                held_ch = c;
                held_ok = 1'b1;
              end
            end else if (!dash_pend) begin
              if (c == ChDash) begin
                dash_pend = 1'b1;
              end else begin
                map_bits[held_ch] = 1'b1;
                if (c == ChClose) begin
                  held_ok = 1'b0;
                  set_phase = PH_CLOSED;
                  r.set_closed = 1'b1;
                end else begin
                  held_ch = c;
                end
              end
            end else if (c == ChClose) begin
              map_bits[held_ch] = 1'b1;
              map_bits[ChDash] = 1'b1;
              held_ok = 1'b0;
              dash_pend = 1'b0;
              set_phase = PH_CLOSED;
              r.set_closed = 1'b1;
            end else begin
              // range; upper bound stays held and may start another range
              for (k = int'(held_ch); k <= int'(c); k++) map_bits[8'(k)] = 1'b1;
              dash_pend = 1'b0;
              held_ch = c;
            end
          end
        end
      end
      CMD_STREAM_CHAR: begin
        if (!fld_over) begin
          close_open_set();
          if (map_bits[c] == is_negated) begin
            r.pushed_back = 1'b1;
            r.field_done = 1'b1;
            r.assigned = got_data;
            fld_over = 1'b1;
          end else begin
            r.accepted = 1'b1;
            if (!cfg_suppress) begin
              r.data_char = c;
              got_data = 1'b1;
            end
            if (width_left != 0) begin
              width_left = width_left - 16'd1;
              if (width_left == 0) begin
                r.field_done = 1'b1;
                r.assigned = got_data;
                fld_over = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        if (!fld_over) begin
          close_open_set();
          r.field_done = 1'b1;
          r.assigned = got_data;
          fld_over = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(input cmd_e cmd, input logic [7:0] c,
                           input bit typed = 1'b0, input res_t typed_res = '0);
    res_t r;
    int   gap;
    int   sel;
    in_valid_i <= 1'b1;
    command_i <= cmd;
    ch_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    r = classify_beat(cmd, c);
    pending_results.push_back(typed ? typed_res : r);
    beats_sent++;
    sel = $urandom_range(0, 99);
    gap = 0;
    if (!no_gaps) begin
      if (sel >= 90) gap = $urandom_range(5, 30);
      else if (sel >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == RegMaxWidth) cfg_width = data[15:0];
    else cfg_suppress = data[0];
  endtask

  // One field: begin, a mostly well-formed bracket expression, stream chars, usually an end.
  task automatic run_field();
    logic [7:0] pool[$];
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    int         n;
    int         sel;
    bit         neg;
    send_beat(CMD_BEGIN, 8'($urandom));
    neg = ($urandom_range(0, 2) == 0);
    if (neg) send_beat(CMD_SET_CHAR, ChCaret);
    if ($urandom_range(0, 3) == 0) begin
      send_beat(CMD_SET_CHAR, ChClose);
      pool.push_back(ChClose);
    end
    n = $urandom_range(0, 5);
    repeat (n) begin
      sel = $urandom_range(0, 9);
      a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(8'h30, 8'h7A));
      if (sel < 4) begin
        send_beat(CMD_SET_CHAR, a);
        pool.push_back(a);
      end else if (sel < 9) begin
        if (sel == 8) b = 8'hFF;
        else if (sel == 7) b = a - 8'($urandom_range(1, 20));
        else b = a + 8'($urandom_range(0, 20));
        send_beat(CMD_SET_CHAR, a);
        send_beat(CMD_SET_CHAR, ChDash);
        send_beat(CMD_SET_CHAR, b);
        pool.push_back(a);
        pool.push_back(b);
        pool.push_back(8'((9'(a) + 9'(b)) >> 1));
      end else begin
        send_beat(CMD_SET_CHAR, ChDash);
        pool.push_back(ChDash);
      end
    end
    if ($urandom_range(0, 4) == 0) send_beat(CMD_SET_CHAR, ChDash);
    if ($urandom_range(0, 6) != 0) send_beat(CMD_SET_CHAR, ChClose);
    if ($urandom_range(0, 5) == 0) send_beat(CMD_SET_CHAR, 8'($urandom));
    n = $urandom_range(1, 10);
    repeat (n) begin
      if (pool.size() != 0 && !neg && $urandom_range(0, 3) != 0)
        c = pool[$urandom_range(0, pool.size() - 1)];
      else
        c = 8'($urandom);
      send_beat(CMD_STREAM_CHAR, c);
    end
    if ($urandom_range(0, 2) != 0) send_beat(CMD_END, 8'($urandom));
    // occasional noise
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 4))
        send_beat(cmd_e'($urandom_range(0, 3)), 8'($urandom));
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(accepted_o));
        check_field("data_char", 32'(want.data_char), 32'(data_char_o));
        check_field("pushed_back", 32'(want.pushed_back), 32'(pushed_back_o));
        check_field("field_done", 32'(want.field_done), 32'(field_done_o));
        check_field("assigned", 32'(want.assigned), 32'(assigned_o));
        check_field("set_closed", 32'(want.set_closed), 32'(set_closed_o));
      end
    end
  end

  // Output backpressure: free-running stretches, short stalls, rare long stalls.
  initial begin : stall_gen
    int sel;
    forever begin
      sel = $urandom_range(0, 9);
      if (sel < 5) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else if (sel < 9) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stim
    int          i;
    int          phase_no;
    int          sel;
    logic [15:0] w;
    dir_tbl = '{
      // stream before any begin: empty set rejects
      '{CMD_STREAM_CHAR, 8'h61, 1'b1, R_REJ0},
      '{CMD_STREAM_CHAR, 8'h62, 1'b1, R_NONE},
      '{CMD_BEGIN,       8'hA5, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    ChCaret, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    ChClose, 1'b1, R_NONE},
      // reversed range x-a adds nothing
      '{CMD_SET_CHAR,    8'h78, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    ChDash, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    8'h61, 1'b1, R_NONE},
      // trailing dash is literal
      '{CMD_SET_CHAR,    ChDash, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    ChClose, 1'b1, R_CLOSED},
      '{CMD_SET_CHAR,    8'h71, 1'b1, R_NONE},
      '{CMD_STREAM_CHAR, 8'h62, 1'b0, R_NONE},
      '{CMD_STREAM_CHAR, ChClose, 1'b1, R_REJ1},
      '{CMD_STREAM_CHAR, 8'h7A, 1'b1, R_NONE},
      '{CMD_END,         8'h5A, 1'b1, R_NONE},
      // width 2 from here; leading dash literal, range up to 255, set left open
      '{CMD_BEGIN,       8'h00, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    ChDash, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    8'h00, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    ChDash, 1'b1, R_NONE},
      '{CMD_SET_CHAR,    8'hFF, 1'b1, R_NONE},
      '{CMD_STREAM_CHAR, 8'h41, 1'b0, R_NONE},
      '{CMD_STREAM_CHAR, 8'h00, 1'b0, R_NONE},
      '{CMD_END,         8'hC3, 1'b1, R_NONE},
      '{CMD_BEGIN,       8'hFF, 1'b1, R_NONE},
      '{CMD_END,         8'hFF, 1'b1, R_DONE0}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      if (i == DirSplit) begin
        wait_drained();
        write_reg(RegMaxWidth, 32'd2);
      end
      send_beat(dir_tbl[i].cmd, dir_tbl[i].ch, dir_tbl[i].typed, dir_tbl[i].res);
    end

    phase_no = 0;
    beats_sent = 0;
    while (beats_sent < RandBeats) begin
      wait_drained();
      sel = $urandom_range(0, 19);
      if (phase_no == 0) w = 16'd0;
      else if (phase_no == 1) w = 16'hFFFF;
      else if (sel < 5) w = 16'd0;
      else if (sel < 13) w = 16'($urandom_range(1, 3));
      else if (sel < 18) w = 16'($urandom_range(4, 20));
      else w = 16'hFFFF;
      write_reg(RegMaxWidth, {16'h0, w});
      write_reg(RegSuppress, (phase_no == 2) ? 32'd1 : 32'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 10)) run_field();
      phase_no++;
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
